### hw/rtl/e2d_pkg.sv
// Shared constants for the extended-to-double converter.
// No dependencies.
package e2d_pkg;
    localparam logic [63:0] SIGN64    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INF64     = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QNAN64    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SNAN64    = 64'h7FF7_FFFF_FFFF_FFFF;
    localparam logic [63:0] ODD_NAN64 = 64'hFFF8_0000_0000_0000;
    localparam logic [14:0] EXP_MAX   = 15'h7FFF;
    localparam logic [15:0] REBIAS    = 16'd15360;
    localparam logic [15:0] DBL_EMAX  = 16'h07FF;
endpackage

### hw/rtl/e2d_if.sv
// Valid/ready channel carrying a generic payload.
// Depends on nothing; payload width set by parameter W.
interface e2d_if #(parameter int W = 64) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/extended_to_double_convert.sv
// Top level of the extended-to-double converter: input register, core, output skid.
// Depends on e2d_pkg, e2d_if and e2d_core.
//
// Usage: i_in carries {sign_exponent, significand} (80 bits); o_out carries
// double_out (64 bits). Both are valid/ready channels; a transfer happens
// when valid and ready are high at a rising edge of i_clk.
// The item is registered on transfer, converted by one level of
// combinational logic and held in the result register.
// Throughput is one item per cycle while the second result entry is empty,
// set by the single-pass conversion logic between input and result registers.
// A two-entry result buffer lets input transfers continue while the
// receiver stalls; ready drops only once both entries are full.
// Reset (i_rst_n low, synchronous) empties the pipeline.
module extended_to_double_convert (
    input  logic  i_clk,
    input  logic  i_rst_n,
    e2d_if.sink   i_in,
    e2d_if.source o_out
);
    logic        r_v;
    logic [79:0] r_in;
    logic [63:0] w_dbl;
    logic        r_ov0, r_ov1;
    logic [63:0] r_o0, r_o1;
    logic        w_adv;

    e2d_core u_core (.i_se(r_in[79:64]), .i_sig(r_in[63:0]), .o_dbl(w_dbl));

    // stage 1 advances when the output buffer has room
    assign w_adv       = !r_ov1;
    assign i_in.ready  = w_adv;
    assign o_out.valid = r_ov0;
    assign o_out.data  = r_o0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_ov0 <= 1'b0;
            r_ov1 <= 1'b0;
        end else begin
            logic pop, push;
            pop  = r_ov0 && o_out.ready;
            push = r_v && w_adv;
            if (w_adv) r_v <= i_in.valid;
            if (pop) begin
                r_ov0 <= r_ov1 || push;
                r_ov1 <= r_ov1 && push;
                r_o0  <= r_ov1 ? r_o1 : w_dbl;
                if (r_ov1 && push) r_o1 <= w_dbl;
            end else if (push) begin
                if (r_ov0) begin
                    r_ov1 <= 1'b1;
                    r_o1  <= w_dbl;
                end else begin
                    r_ov0 <= 1'b1;
                    r_o0  <= w_dbl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_in.valid) r_in <= i_in.data;
    end
endmodule

### hw/rtl/e2d_core.sv
// Combinational conversion of an 80-bit extended value to a binary64 pattern.
// Uses e2d_pkg constants.
module e2d_core (
    input  logic [15:0] i_se,
    input  logic [63:0] i_sig,
    output logic [63:0] o_dbl
);
    logic [63:0]  sgn;
    logic [14:0]  e;
    logic [15:0]  be;
    logic [15:0]  nbe;
    logic [6:0]   sh;
    logic [127:0] wide;
    logic [63:0]  kept;
    logic [63:0]  rest;
    logic [63:0]  half;
    logic         up;
    logic [63:0]  nkept;
    logic [63:0]  nrm;
    logic         nup;

    always_comb begin
        sgn   = i_se[15] ? e2d_pkg::SIGN64 : 64'd0;
        e     = i_se[14:0];
        be    = {1'b0, e} - e2d_pkg::REBIAS;
        nbe   = 16'd0 - be;
        sh    = 7'd12 + nbe[6:0];
        // normal path: drop integer bit, round away 11 low bits
        nup   = i_sig[10] && (i_sig[9:0] != 10'd0 || i_sig[11]);
        nrm   = {be[11:0], i_sig[62:11]} + {63'd0, nup};
        // tiny path: shift right by 12..64
        wide  = {i_sig, 64'd0} >> sh;
        kept  = wide[127:64];
        rest  = wide[63:0];
        half  = 64'h8000_0000_0000_0000;
        up    = (rest > half) || (rest == half && kept[0]);
        nkept = kept + {63'd0, up};
        if (e == 15'd0) begin
            o_dbl = sgn;
        end else if (e == e2d_pkg::EXP_MAX) begin
            if (i_sig[62:0] == 63'd0)
                o_dbl = i_sig[63] ? (sgn | e2d_pkg::INF64) : e2d_pkg::ODD_NAN64;
            else
                o_dbl = sgn | (i_sig[62] ? e2d_pkg::QNAN64 : e2d_pkg::SNAN64);
        end else if (!i_sig[63]) begin
            o_dbl = e2d_pkg::ODD_NAN64;
        end else if (!be[15] && be >= e2d_pkg::DBL_EMAX) begin
            o_dbl = sgn | e2d_pkg::INF64;
        end else if (!be[15] && be != 16'd0) begin
            o_dbl = sgn | nrm;
        end else if (nbe > 16'd52) begin
            o_dbl = sgn;
        end else begin
            o_dbl = sgn | nkept;
        end
    end
endmodule

### hw/rtl/e2d_checker.sv
// Port-level checks for extended_to_double_convert.
// Bound to the top level; observes the channel interfaces only.
module e2d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |=> i_in_ready)
        else $error("input blocked although receiver drained");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> ##1 i_out_valid)
        else $error("result missing after two cycles");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind extended_to_double_convert e2d_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready), .i_out_data(o_out.data)
);
